[hdl/egb_pkg.sv]
// shared types and constants of the epsilon-greedy bandit agent
`timescale 1ns / 1ps

package egb_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_AVG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ALPHA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTION_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_MODE   = 3'd5;

    // opcodes
    localparam logic OP_PROPOSE = 1'b0;
    localparam logic OP_OUTCOME = 1'b1;

    // q1.16 one and dividend width of the shared divider
    localparam logic [16:0] Q_ONE = 17'h10000;
    localparam int DVD_W = 48;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_rd;
        logic pick;
        logic sel_best;
        logic rd_last;
        logic ofetch;
        logic div_rt;
        logic tgt_div;
        logic diff;
        logic div_cnt;
        logic mul;
        logic delta_mul;
        logic delta_div;
        logic upd;
        logic div_act;
        logic res_load;
    } egb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic op;
        logic explore;
        logic scan_last;
        logic rt_div;
        logic samp;
        logic div_busy;
        logic out_hold;
    } egb_sts_t;

endpackage

[hdl/egb_div.sv]
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module egb_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    // one trial subtraction
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    // shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hdl/egb_dp.sv]
// datapath: configuration, value and count tables, arithmetic, result register
`timescale 1ns / 1ps

module egb_dp #(
    parameter int MAX_ACTIONS = 32,
    parameter int MAX_MOVES   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  egb_pkg::egb_cmd_t              cmd,
    output egb_pkg::egb_sts_t              sts,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [egb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [egb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           opcode,
    input  logic [15:0]                    explore_draw,
    input  logic [15:0]                    pick_draw,
    input  logic signed [31:0]             reward,
    input  logic                           time_scaled,
    input  logic [31:0]                    move_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [4:0]                     action,
    output logic [3:0]                     move_kind,
    output logic [4:0]                     block_slot,
    output logic                           block_valid,
    output logic                           explored,
    output logic signed [31:0]             updated_value
);

    import egb_pkg::*;

    localparam int AW    = $clog2(MAX_ACTIONS);
    localparam int NW    = AW + 1;
    localparam int CW    = (NW > 6) ? NW : 6;
    localparam int MW0   = $clog2(MAX_MOVES + 1);
    localparam int MCW   = (MW0 > 5) ? MW0 : 5;
    localparam int DVS_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

    // configuration registers
    logic [16:0] epsilon_reg;
    logic        samp_reg;
    logic [16:0] alpha_reg;
    logic [4:0]  mcount_reg;
    logic [5:0]  acount_reg;
    logic        bmode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= '0;
            samp_reg    <= 1'b1;
            alpha_reg   <= '0;
            mcount_reg  <= 5'd1;
            acount_reg  <= 6'd1;
            bmode_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_EPSILON:      epsilon_reg <= cfg_data[16:0];
                REG_SAMPLE_AVG:   samp_reg    <= cfg_data[0];
                REG_STEP_ALPHA:   alpha_reg   <= cfg_data[16:0];
                REG_MOVE_COUNT:   mcount_reg  <= cfg_data[4:0];
                REG_ACTION_COUNT: acount_reg  <= cfg_data[5:0];
                REG_BLOCK_MODE:   bmode_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // clamped action and move counts
    logic [CW-1:0]  ac_w;
    logic [NW-1:0]  n_eff;
    logic [MCW-1:0] mc_w;
    logic [MCW-1:0] m_eff;

    always_comb
    begin
        ac_w = CW'(acount_reg);
        if (ac_w == '0)
            n_eff = NW'(1);
        else if (ac_w > CW'(MAX_ACTIONS))
            n_eff = NW'(MAX_ACTIONS);
        else
            n_eff = NW'(ac_w);
        mc_w = MCW'(mcount_reg);
        if (mc_w == '0)
            m_eff = MCW'(1);
        else if (mc_w > MCW'(MAX_MOVES))
            m_eff = MCW'(MAX_MOVES);
        else
            m_eff = mc_w;
    end

    // latched input beat
    logic               op_reg;
    logic               explore_reg;
    logic [15:0]        pdraw_reg;
    logic signed [31:0] reward_reg;
    logic               raware_reg;
    logic [31:0]        mtime_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= opcode;
            explore_reg <= (opcode == OP_PROPOSE) && ({1'b0, explore_draw} < epsilon_reg);
            pdraw_reg   <= pick_draw;
            reward_reg  <= reward;
            raware_reg  <= time_scaled;
            mtime_reg   <= move_time;
        end
    end

    // tables, valid bit per entry stands for the all-zero reset
    logic signed [31:0]     val_mem [MAX_ACTIONS];
    logic [COUNT_WIDTH-1:0] cnt_mem [MAX_ACTIONS];
    logic [MAX_ACTIONS-1:0] ent_vld_reg;
    logic [AW-1:0]          last_action_reg;
    logic [AW-1:0]          scan_idx_reg;
    logic [AW-1:0]          rd_addr;
    logic signed [31:0]     rd_val_reg;
    logic [COUNT_WIDTH-1:0] rd_cnt_reg;
    logic                   rd_vld_reg;
    logic signed [31:0]     q_eff;
    logic [COUNT_WIDTH-1:0] cnt_eff;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic signed [31:0]     nv;
    logic                   val_we;
    logic signed [31:0]     val_wdata;

    assign rd_addr   = cmd.scan_rd ? scan_idx_reg : last_action_reg;
    assign q_eff     = rd_vld_reg ? rd_val_reg : 32'sd0;
    assign cnt_eff   = rd_vld_reg ? rd_cnt_reg : '0;
    assign cnt_inc   = (cnt_eff == '1) ? cnt_eff : cnt_eff + 1'b1;
    assign val_we    = cmd.ofetch | cmd.upd;
    assign val_wdata = cmd.upd ? nv : q_eff;

    // memory ports
    always_ff @(posedge clk)
    begin
        rd_val_reg <= val_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
        if (val_we)
            val_mem[last_action_reg] <= val_wdata;
        if (cmd.ofetch)
            cnt_mem[last_action_reg] <= cnt_inc;
    end

    // argmax scan pipeline
    logic               cmp_v_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic signed [31:0] best_reg;
    logic [AW-1:0]      best_idx_reg;
    logic signed [31:0] scan_val;

    assign scan_val = rd_vld_reg ? rd_val_reg : 32'sd0;

    // explored pick: ceil(p*n) - 1 clamped to n - 1
    logic [16+NW:0] pk_sum;
    logic [NW:0]    pk_c;
    logic [NW:0]    pk_cm1;
    logic [AW-1:0]  pk_idx;

    always_comb
    begin
        pk_sum = (17+NW)'(pdraw_reg) * (17+NW)'(n_eff) + (17+NW)'(16'hFFFF);
        pk_c   = pk_sum[16+NW:16];
        pk_cm1 = (pk_c == '0) ? '0 : pk_c - 1'b1;
        if (pk_cm1 > (NW+1)'(n_eff - 1'b1))
            pk_idx = AW'(n_eff - 1'b1);
        else
            pk_idx = AW'(pk_cm1);
    end

    // shared divider
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_busy;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;

    // arithmetic registers
    logic signed [31:0]     q_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic signed [31:0]     target_reg;
    logic signed [32:0]     diff_reg;
    logic [32:0]            diff_mag;
    logic [31:0]            rew_mag;
    logic [49:0]            mul_reg;
    logic [16:0]            alpha_eff;
    logic signed [34:0]     delta_reg;
    logic signed [35:0]     nv_sum;
    logic [AW-1:0]          action_reg;
    logic signed [31:0]     res_val_reg;
    logic signed [31:0]     tgt_direct;
    logic signed [31:0]     tgt_quo;

    assign rew_mag   = reward_reg[31] ? (~reward_reg + 1'b1) : reward_reg;
    assign diff_mag  = diff_reg[32] ? (~diff_reg + 1'b1) : diff_reg;
    assign alpha_eff = (alpha_reg > Q_ONE) ? Q_ONE : alpha_reg;
    assign div_start = cmd.div_rt | cmd.div_cnt | cmd.div_act;

    always_comb
    begin
        if (cmd.div_rt)
        begin
            div_dvd = {rew_mag, 16'h0000};
            div_dvs = DVS_W'(mtime_reg);
        end
        else if (cmd.div_cnt)
        begin
            div_dvd = DVD_W'(diff_mag);
            div_dvs = DVS_W'(cnt_reg);
        end
        else
        begin
            div_dvd = DVD_W'(action_reg);
            div_dvs = DVS_W'(m_eff);
        end
    end

    egb_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // target without a division, zero move time saturates by sign
    always_comb
    begin
        if (raware_reg)
        begin
            if (reward_reg > 32'sd0)
                tgt_direct = 32'sh7FFFFFFF;
            else if (reward_reg < 32'sd0)
                tgt_direct = 32'sh80000000;
            else
                tgt_direct = 32'sd0;
        end
        else
            tgt_direct = reward_reg;
    end

    // signed, saturated runtime quotient
    always_comb
    begin
        if (!reward_reg[31])
            tgt_quo = (div_quo > DVD_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : div_quo[31:0];
        else if (div_quo > DVD_W'(32'h80000000))
            tgt_quo = 32'sh80000000;
        else
            tgt_quo = ~div_quo[31:0] + 1'b1;
    end

    // new value, saturated
    always_comb
    begin
        nv_sum = $signed({{4{q_reg[31]}}, q_reg}) + $signed({delta_reg[34], delta_reg});
        if (nv_sum > 36'sh07FFFFFFF)
            nv = 32'sh7FFFFFFF;
        else if (nv_sum < -36'sh080000000)
            nv = 32'sh80000000;
        else
            nv = nv_sum[31:0];
    end

    // control registers of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_vld_reg     <= '0;
            rd_vld_reg      <= 1'b0;
            last_action_reg <= '0;
            scan_idx_reg    <= '0;
            cmp_v_reg       <= 1'b0;
            out_valid       <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= ent_vld_reg[rd_addr];
            if (val_we)
                ent_vld_reg[last_action_reg] <= 1'b1;
            if (cmd.scan_clr)
                scan_idx_reg <= '0;
            else if (cmd.scan_rd)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            cmp_v_reg <= cmd.scan_rd;
            if (cmd.pick)
                last_action_reg <= pk_idx;
            else if (cmd.sel_best)
                last_action_reg <= best_idx_reg;
            if (cmd.res_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (cmp_v_reg && ((cmp_idx_reg == '0) || (scan_val > best_reg)))
        begin
            best_reg     <= scan_val;
            best_idx_reg <= cmp_idx_reg;
        end
        if (cmd.load)
            res_val_reg <= 32'sd0;
        if (cmd.pick)
            action_reg <= pk_idx;
        if (cmd.sel_best)
            action_reg <= best_idx_reg;
        if (cmd.ofetch)
        begin
            action_reg <= last_action_reg;
            q_reg      <= q_eff;
            cnt_reg    <= cnt_inc;
            target_reg <= tgt_direct;
        end
        if (cmd.tgt_div)
            target_reg <= tgt_quo;
        if (cmd.diff)
            diff_reg <= {target_reg[31], target_reg} - {q_reg[31], q_reg};
        if (cmd.mul)
            mul_reg <= 50'(diff_mag) * 50'(alpha_eff);
        if (cmd.delta_mul)
            delta_reg <= diff_reg[32] ? -$signed({1'b0, mul_reg[49:16]})
                                      : $signed({1'b0, mul_reg[49:16]});
        if (cmd.delta_div)
            delta_reg <= diff_reg[32] ? -$signed({1'b0, div_quo[33:0]})
                                      : $signed({1'b0, div_quo[33:0]});
        if (cmd.upd)
            res_val_reg <= nv;
        if (cmd.res_load)
        begin
            action        <= 5'(action_reg);
            move_kind     <= div_rem[3:0];
            block_slot    <= bmode_reg ? div_quo[4:0] : 5'd0;
            block_valid   <= bmode_reg;
            explored      <= explore_reg;
            updated_value <= res_val_reg;
        end
    end

    // status
    assign sts.op        = op_reg;
    assign sts.explore   = explore_reg;
    assign sts.scan_last = (NW'(scan_idx_reg) == n_eff - 1'b1);
    assign sts.rt_div    = raware_reg && (mtime_reg != 32'd0);
    assign sts.samp      = samp_reg;
    assign sts.div_busy  = div_busy;
    assign sts.out_hold  = out_valid && !out_ready;

`ifndef ASSERT_OFF
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> !(out_valid && !out_ready))
        else $error("result register overwritten before its beat was taken");
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> (NW'(scan_idx_reg) < n_eff))
        else $error("scan read beyond the action count");
`endif

endmodule

[hdl/egb_ctrl.sv]
// controller state machine sequencing proposals and outcomes
`timescale 1ns / 1ps

module egb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  egb_pkg::egb_sts_t sts,
    output egb_pkg::egb_cmd_t cmd
);

    import egb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_PICK,
        S_SCAN,
        S_SCANW,
        S_SEL,
        S_OFETCH,
        S_RTGO,
        S_RTWAIT,
        S_DIFF,
        S_CNTGO,
        S_CNTWAIT,
        S_MUL,
        S_MULD,
        S_UPD,
        S_ADGO,
        S_ADWAIT,
        S_OUTW
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_DECODE;
            S_DECODE:
            begin
                if (sts.op == OP_OUTCOME)
                    state_next = S_OFETCH;
                else if (sts.explore)
                    state_next = S_PICK;
                else
                    state_next = S_SCAN;
            end
            S_PICK:    state_next = S_ADGO;
            S_SCAN:    if (sts.scan_last) state_next = S_SCANW;
            S_SCANW:   state_next = S_SEL;
            S_SEL:     state_next = S_ADGO;
            S_OFETCH:  state_next = sts.rt_div ? S_RTGO : S_DIFF;
            S_RTGO:    state_next = S_RTWAIT;
            S_RTWAIT:  if (!sts.div_busy) state_next = S_DIFF;
            S_DIFF:    state_next = sts.samp ? S_CNTGO : S_MUL;
            S_CNTGO:   state_next = S_CNTWAIT;
            S_CNTWAIT: if (!sts.div_busy) state_next = S_UPD;
            S_MUL:     state_next = S_MULD;
            S_MULD:    state_next = S_UPD;
            S_UPD:     state_next = S_ADGO;
            S_ADGO:    state_next = S_ADWAIT;
            S_ADWAIT:  if (!sts.div_busy) state_next = S_OUTW;
            S_OUTW:    if (!sts.out_hold) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.scan_clr  = (state_reg == S_DECODE);
        cmd.scan_rd   = (state_reg == S_SCAN);
        cmd.pick      = (state_reg == S_PICK);
        cmd.sel_best  = (state_reg == S_SEL);
        cmd.rd_last   = (state_reg == S_DECODE) && (sts.op == OP_OUTCOME);
        cmd.ofetch    = (state_reg == S_OFETCH);
        cmd.div_rt    = (state_reg == S_RTGO);
        cmd.tgt_div   = (state_reg == S_RTWAIT) && !sts.div_busy;
        cmd.diff      = (state_reg == S_DIFF);
        cmd.div_cnt   = (state_reg == S_CNTGO);
        cmd.delta_div = (state_reg == S_CNTWAIT) && !sts.div_busy;
        cmd.mul       = (state_reg == S_MUL);
        cmd.delta_mul = (state_reg == S_MULD);
        cmd.upd       = (state_reg == S_UPD);
        cmd.div_act   = (state_reg == S_ADGO);
        cmd.res_load  = (state_reg == S_OUTW) && !sts.out_hold;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

[hdl/epsilon_greedy_bandit_agent.sv]
// An exploring proposal picks its action from the draw; a greedy one scans the N actions.
// An outcome takes the 1/count step through a division or the fixed step through a multiply,
// after a runtime division of the reward by the move time where that applies.
// Each division runs on the one shared restoring divider.
// One item is in work at a time; the next beat is taken once the result is registered.
// Reset (rst_n, asynchronous, active low) clears control state and the per-entry valid bits,
// so all values and counts read as zero without a clearing pass; configuration takes its defaults.
`timescale 1ns / 1ps

module epsilon_greedy_bandit_agent #(
    parameter int MAX_ACTIONS = 32,
    parameter int MAX_MOVES   = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [egb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [egb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [15:0]                    explore_draw,
    input  logic [15:0]                    pick_draw,
    input  logic signed [31:0]             reward,
    input  logic                           time_scaled,
    input  logic [31:0]                    move_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [4:0]                     action,
    output logic [3:0]                     move_kind,
    output logic [4:0]                     block_slot,
    output logic                           block_valid,
    output logic                           explored,
    output logic signed [31:0]             updated_value
);

    import egb_pkg::*;

    egb_cmd_t cmd;
    egb_sts_t sts;

    egb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    egb_dp #(
        .MAX_ACTIONS (MAX_ACTIONS),
        .MAX_MOVES   (MAX_MOVES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .explore_draw  (explore_draw),
        .pick_draw     (pick_draw),
        .reward        (reward),
        .time_scaled   (time_scaled),
        .move_time     (move_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .move_kind     (move_kind),
        .block_slot    (block_slot),
        .block_valid   (block_valid),
        .explored      (explored),
        .updated_value (updated_value)
    );

endmodule

[test/tb_top.sv]
// self-checking testbench for the epsilon-greedy bandit agent
`timescale 1ns / 1ps

module tb_top;
    import egb_pkg::*;

    localparam int NUM_ARMS    = 32;
    localparam int IDLE_LIMIT  = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE_CYC  = 400;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic              op;
        logic [15:0]       edraw;
        logic [15:0]       pdraw;
        logic signed [31:0] rwd;
        logic              raware;
        logic [31:0]       mtime;
    } bandit_item_t;

    typedef struct packed {
        logic [4:0]        act;
        logic [3:0]        mtype;
        logic [4:0]        slot;
        logic              bvalid;
        logic              expl;
        logic signed [31:0] value;
    } bandit_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic opcode = 1'b0;
    logic [15:0] explore_draw = '0;
    logic [15:0] pick_draw = '0;
    logic signed [31:0] reward = '0;
    logic time_scaled = 1'b0;
    logic [31:0] move_time = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [4:0] action;
    logic [3:0] move_kind;
    logic [4:0] block_slot;
    logic block_valid;
    logic explored;
    logic signed [31:0] updated_value;

    epsilon_greedy_bandit_agent dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .explore_draw(explore_draw), .pick_draw(pick_draw),
        .reward(reward), .time_scaled(time_scaled), .move_time(move_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .action(action), .move_kind(move_kind), .block_slot(block_slot),
        .block_valid(block_valid), .explored(explored), .updated_value(updated_value)
    );

    // clock
    always #10 clk = ~clk;

    // shadow of the agent: configuration and tables
    logic [16:0] sh_eps   = 17'd0;
    logic        sh_samp  = 1'b1;
    logic [16:0] sh_alpha = 17'd0;
    logic [4:0]  sh_moves = 5'd1;
    logic [5:0]  sh_arms  = 6'd1;
    logic        sh_bmode = 1'b0;
    logic signed [31:0] arm_value [NUM_ARMS];
    longint unsigned    arm_picks [NUM_ARMS];
    logic [4:0]  last_arm = '0;

    bandit_item_t   pending_items [$];
    bandit_result_t expected_results [$];

    int errors = 0;
    int items_in = 0;
    int results_out = 0;
    int cfg_writes = 0;
    int explore_seen = 0;
    int outcome_seen = 0;

    initial begin
        for (int i = 0; i < NUM_ARMS; i++) begin
            arm_value[i] = '0;
            arm_picks[i] = 0;
        end
    end

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // append one item to the driver's queue
    task automatic add_item(input bandit_item_t it);
        pending_items = {pending_items, it};
    endtask

    // work out the result of one accepted beat and advance the shadow tables
    task automatic predict_bandit(input bandit_item_t it);
        bandit_result_t r;
        longint unsigned n, m, c, cnt;
        longint rw, tgt, q, diff, delta, mt, al;
        logic [4:0] a;
        n = (sh_arms == 0) ? 1 : ((sh_arms > NUM_ARMS) ? NUM_ARMS : sh_arms);
        m = (sh_moves == 0) ? 1 : ((sh_moves > 16) ? 16 : sh_moves);
        r = '0;
        if (it.op == OP_PROPOSE) begin
            a = '0;
            r.expl = (it.edraw < sh_eps);
            if (r.expl) begin
                c = (longint'(it.pdraw) * n + 65535) >> 16;
                a = (c == 0) ? 5'd0 : 5'(c - 1);
                if (a > n - 1) a = 5'(n - 1);
                explore_seen++;
            end else begin
                for (int i = 1; i < n; i++)
                    if (arm_value[i] > arm_value[a]) a = 5'(i);
            end
            last_arm = a;
            r.value = '0;
        end else begin
            a = last_arm;
            if (arm_picks[a] < 64'hFFFF_FFFF) arm_picks[a]++;
            rw = $signed(it.rwd);
            tgt = rw;
            if (it.raware) begin
                if (it.mtime == 0)
                    tgt = (rw > 0) ? 64'sd2147483647 : ((rw < 0) ? -64'sd2147483648 : 0);
                else begin
                    mt = {32'd0, it.mtime};
                    tgt = clamp_s32((rw * 65536) / mt);
                end
            end
            q = arm_value[a];
            diff = tgt - q;
            if (sh_samp) begin
                cnt = (arm_picks[a] == 0) ? 1 : arm_picks[a];
                delta = diff / longint'(cnt);
            end else begin
                al = (sh_alpha > 17'd65536) ? 65536 : {47'd0, sh_alpha};
                delta = (diff * al) / 65536;
            end
            arm_value[a] = 32'(clamp_s32(q + delta));
            r.value = arm_value[a];
            r.expl = 1'b0;
            outcome_seen++;
        end
        r.act    = a;
        r.mtype  = 4'(a % m);
        r.slot   = sh_bmode ? 5'(a / m) : 5'd0;
        r.bvalid = sh_bmode;
        expected_results = {expected_results, r};
    endtask

    // register shadow follows every accepted write
    always @(posedge clk) begin
        if (rst_n && cfg_valid && cfg_ready) begin
            cfg_writes++;
            case (cfg_index)
                REG_EPSILON:      sh_eps   = cfg_data;
                REG_SAMPLE_AVG:   sh_samp  = cfg_data[0];
                REG_STEP_ALPHA:   sh_alpha = cfg_data;
                REG_MOVE_COUNT:   sh_moves = cfg_data[4:0];
                REG_ACTION_COUNT: sh_arms  = cfg_data[5:0];
                REG_BLOCK_MODE:   sh_bmode = cfg_data[0];
                default: ;
            endcase
        end
    end

    // input driver: bursts of beats with random gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_bandit({opcode, explore_draw, pick_draw, reward,
                                time_scaled, move_time});
                items_in++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    bandit_item_t it;
                    it = pending_items.pop_front();
                    opcode        <= it.op;
                    explore_draw  <= it.edraw;
                    pick_draw     <= it.pdraw;
                    reward        <= it.rwd;
                    time_scaled   <= it.raware;
                    move_time     <= it.mtime;
                    in_valid      <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
                        gap_left   = (burst_left == 40) ? 0 : $urandom_range(0, 70);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes every so often, one long hold-off
    int hold_left = 0;
    int pattern_left = 0;
    int ready_pct = 100;
    bit held_once = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(100, 600);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 50;
                    2: ready_pct = 20;
                    default: ready_pct = 80;
                endcase
            end else begin
                pattern_left--;
            end
            if (!held_once && items_in >= 500) begin
                held_once = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            bandit_result_t e;
            results_out++;
            if (expected_results.size() == 0) begin
                $error("unexpected result beat: action %0d value %0d", action, updated_value);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (action !== e.act) begin
                    $error("action: expected %0d, got %0d", e.act, action);
                    errors++;
                end
                if (move_kind !== e.mtype) begin
                    $error("move_kind: expected %0d, got %0d", e.mtype, move_kind);
                    errors++;
                end
                if (block_slot !== e.slot) begin
                    $error("block_slot: expected %0d, got %0d", e.slot, block_slot);
                    errors++;
                end
                if (block_valid !== e.bvalid) begin
                    $error("block_valid: expected %0d, got %0d", e.bvalid, block_valid);
                    errors++;
                end
                if (explored !== e.expl) begin
                    $error("explored: expected %0d, got %0d", e.expl, explored);
                    errors++;
                end
                if (updated_value !== e.value) begin
                    $error("updated_value: expected %0d, got %0d", e.value, updated_value);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("** epsilon_greedy_bandit_agent: FAILED **");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [16:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [16:0] eps, input logic samp, input logic [16:0] al,
                              input logic [4:0] mv, input logic [5:0] na, input logic bm);
        write_reg(REG_EPSILON, eps);
        write_reg(REG_SAMPLE_AVG, {16'd0, samp});
        write_reg(REG_STEP_ALPHA, al);
        write_reg(REG_MOVE_COUNT, {12'd0, mv});
        write_reg(REG_ACTION_COUNT, {11'd0, na});
        write_reg(REG_BLOCK_MODE, {16'd0, bm});
    endtask

    // wait until every queued beat went in and every result came back
    task automatic drain;
        do @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic bandit_item_t make_item(input logic op, input logic [15:0] ed,
                                               input logic [15:0] pd, input logic signed [31:0] rw,
                                               input logic ra, input logic [31:0] mt);
        return {op, ed, pd, rw, ra, mt};
    endfunction

    function automatic bandit_item_t rand_item(input logic op);
        bandit_item_t it;
        it.op = op;
        case ($urandom_range(0, 5))
            0: it.edraw = 16'h0000;
            1: it.edraw = 16'hFFFF;
            default: it.edraw = 16'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0: it.pdraw = 16'h0000;
            1: it.pdraw = 16'hFFFF;
            default: it.pdraw = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: it.rwd = 32'sh7FFF_FFFF;
            1: it.rwd = 32'sh8000_0000;
            2: it.rwd = '0;
            3, 4: it.rwd = (int'($urandom_range(0, 16)) - 8) <<< 16;
            default: it.rwd = $urandom;
        endcase
        it.raware = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: it.mtime = '0;
            1: it.mtime = 32'd1;
            2: it.mtime = 32'hFFFF_FFFF;
            3, 4, 5: it.mtime = $urandom_range(1 << 14, 1 << 18);
            default: it.mtime = $urandom;
        endcase
        return it;
    endfunction

    // mostly propose/outcome pairs, some stray opcodes
    task automatic queue_random(input int count);
        logic op;
        op = OP_PROPOSE;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 4) == 0) add_item(rand_item(1'($urandom_range(0, 1))));
            else begin
                add_item(rand_item(op));
                op = ~op;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: outcome before any proposal hits arm zero, then a greedy proposal
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh0064_0000, 1'b0, '0));
        add_item(make_item(OP_PROPOSE, 16'hFFFF, 16'hFFFF, '0, 1'b0, '0));
        drain();

        // always explore over the full table, draw extremes
        set_config(17'd65536, 1'b1, 17'd0, 5'd16, 6'd32, 1'b1);
        write_reg(REG_UNMAPPED_LO, 17'h1FFFF);
        write_reg(REG_UNMAPPED_HI, 17'h00001);
        add_item(make_item(OP_PROPOSE, 16'hFFFF, 16'h0000, '0, 1'b0, '0));
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh7FFF_FFFF, 1'b1, 32'd0));
        add_item(make_item(OP_PROPOSE, 16'h0000, 16'h0001, '0, 1'b0, '0));
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh8000_0000, 1'b1, 32'd0));
        add_item(make_item(OP_PROPOSE, 16'h1234, 16'h0800, '0, 1'b0, '0));
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh0000_0000, 1'b1, 32'd0));
        add_item(make_item(OP_PROPOSE, 16'h0000, 16'h8000, '0, 1'b0, '0));
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh7FFF_FFFF, 1'b1, 32'd1));
        add_item(make_item(OP_PROPOSE, 16'h0000, 16'hC000, '0, 1'b0, '0));
        add_item(make_item(OP_OUTCOME, '0, '0, -32'sd300000, 1'b1, 32'hFFFF_FFFF));
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh8000_0000, 1'b0, '0));
        add_item(make_item(OP_PROPOSE, 16'hFFFF, 16'hFFFF, '0, 1'b0, '0));
        drain();

        // table shrunk after proposing arm 31: outcome still lands on it; fixed steps
        set_config(17'd0, 1'b0, 17'd65536, 5'd0, 6'd0, 1'b0);
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh7FFF_FFFF, 1'b0, '0));
        add_item(make_item(OP_PROPOSE, 16'hFFFF, 16'h0000, '0, 1'b0, '0));
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh8000_0000, 1'b0, '0));
        drain();
        set_config(17'h1FFFF, 1'b0, 17'h1FFFF, 5'd31, 6'd63, 1'b1);
        add_item(make_item(OP_PROPOSE, 16'hFFFF, 16'hFFFF, '0, 1'b0, '0));
        add_item(make_item(OP_OUTCOME, '0, '0, 32'sh0001_0000, 1'b0, '0));
        drain();

        // random phases over a spread of settings
        set_config(17'd32768, 1'b1, 17'd0, 5'd5, 6'd32, 1'b1);
        queue_random(230);
        drain();
        set_config(17'd6554, 1'b0, 17'd6554, 5'd4, 6'd7, 1'b1);
        queue_random(230);
        drain();
        set_config(17'd0, 1'b1, 17'd1, 5'd16, 6'd32, 1'b0);
        queue_random(220);
        drain();
        set_config(17'd65536, 1'b0, 17'd0, 5'd1, 6'd1, 1'b1);
        queue_random(200);
        drain();
        set_config(17'd65535, 1'b0, 17'd65535, 5'd3, 6'd32, 1'b1);
        queue_random(230);
        drain();
        set_config(17'h1FFFF, 1'b1, 17'h1FFFF, 5'd31, 6'd63, 1'b0);
        queue_random(220);
        drain();
        set_config(17'd20000, 1'b0, 17'd40000, 5'd0, 6'd0, 1'b1);
        queue_random(200);
        drain();
        set_config(17'd16384, 1'b1, 17'd1000, 5'd7, 6'd20, 1'b1);
        queue_random(230);
        drain();

        $display("covered %0d input beats (%0d outcomes, %0d explored proposals), %0d results,",
                 items_in, outcome_seen, explore_seen, results_out);
        $display("%0d register writes across eleven settings, one long output hold-off",
                 cfg_writes);
        if (errors == 0)
            $display("** epsilon_greedy_bandit_agent: PASSED **");
        else
            $display("** epsilon_greedy_bandit_agent: FAILED **");
        $finish;
    end

endmodule
